### rtl/core/gn3_pkg.sv
// gradient noise 3d package: shared constants and the item mode code
// no dependencies; compiled first

package gn3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TABLE_SIZE    = 256;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int PERM_W        = 8;
  localparam int COORD_W       = 32;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

endpackage

### rtl/core/gn3_if.sv
// gradient noise 3d channel interfaces: input beat and result beat
// depends on gn3_pkg

interface gn3_in_if
  import gn3_pkg::*;
;
  logic                      valid;
  logic                      ready;
  mode_e                     mode;
  logic [IDX_W-1:0]          table_index;
  logic [PERM_W-1:0]         table_value;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, mode, table_index, table_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, mode, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface gn3_out_if
  import gn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [FRAC_BITS+2:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

### rtl/core/gn3_perm_ram.sv
// gradient noise 3d permutation table copy: one write port, two registered read ports
// depends on gn3_pkg

module gn3_perm_ram
  import gn3_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [PERM_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]  raddr0_i,
  input  logic [IDX_W-1:0]  raddr1_i,
  output logic [PERM_W-1:0] rdata0_o,
  output logic [PERM_W-1:0] rdata1_o
);

  logic [PERM_W-1:0] mem_q [TABLE_SIZE];
  logic [PERM_W-1:0] rdata0_q;
  logic [PERM_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[waddr_i] <= wdata_i;
      end
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

### rtl/core/gn3_fade.sv
// gradient noise 3d quintic fade 6t^5-15t^4+10t^3, three register stages
// depends on gn3_pkg

module gn3_fade
  import gn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic [FRAC_BITS-1:0] fade_o
);

  localparam int GW = FRAC_BITS + 5;

  logic [FRAC_BITS-1:0]   t2_q, f1_q, t3_q, fade_q;
  logic [FRAC_BITS+3:0]   g_q;
  logic [2*FRAC_BITS-1:0] sq_d, cube_d;
  logic [GW-1:0]          g_d;
  logic [2*FRAC_BITS+3:0] prod_d;

  assign sq_d   = (2*FRAC_BITS)'(frac_i) * (2*FRAC_BITS)'(frac_i);
  assign cube_d = (2*FRAC_BITS)'(t2_q) * (2*FRAC_BITS)'(f1_q);
  assign g_d    = GW'(t2_q) * GW'(6) + (GW'(10) << FRAC_BITS) - GW'(f1_q) * GW'(15);
  assign prod_d = (2*FRAC_BITS+4)'(t3_q) * (2*FRAC_BITS+4)'(g_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q   <= sq_d[2*FRAC_BITS-1:FRAC_BITS];
      f1_q   <= frac_i;
      t3_q   <= cube_d[2*FRAC_BITS-1:FRAC_BITS];
      g_q    <= g_d[FRAC_BITS+3:0];
      fade_q <= prod_d[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  assign fade_o = fade_q;

endmodule

### rtl/core/gn3_lerp.sv
// gradient noise 3d linear blend a + t*(b-a)/one, truncating toward zero
// two stages: multiply, then scale and add; depends on gn3_pkg

module gn3_lerp
  import gn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+2:0] a_i,
  input  logic signed [FRAC_BITS+2:0] b_i,
  input  logic        [FRAC_BITS-1:0] t_i,
  output logic signed [FRAC_BITS+2:0] res_o
);

  localparam int VW = FRAC_BITS + 3;
  localparam int DW = FRAC_BITS + 4;
  localparam int PW = 2*FRAC_BITS + 5;

  logic signed [DW-1:0] diff_d;
  logic signed [PW-1:0] prod_d, prod_q, quo_d;
  logic signed [VW-1:0] a_q, res_q;

  assign diff_d = DW'(b_i) - DW'(a_i);
  assign prod_d = PW'($signed({1'b0, t_i})) * PW'(diff_d);

  always_comb begin
    quo_d = prod_q >>> FRAC_BITS;
    if (prod_q[PW-1] && (|prod_q[FRAC_BITS-1:0])) begin
      quo_d = quo_d + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      res_q  <= a_q + quo_d[VW-1:0];
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/gradient_noise_3d_unit.sv
// gradient noise 3d top level: hash pipeline, gradients, fade and blend tree
// depends on gn3_pkg, gn3_if, gn3_perm_ram, gn3_fade, gn3_lerp
//
// in_i carries one beat per item: mode write stores table_value at table_index of the
// permutation table, mode sample evaluates noise at signed coord_x/y/z with FRAC_BITS
// fraction bits. out_o returns one noise_value per sample beat, none for write beats,
// in input order.
// throughput: one beat per cycle unless out_o stalls; the table is held in seven
// copies (one per hash level read pair), so every corner lookup has its own read port.
// writes travel the pipeline and update each copy in order with the samples around them.
// the table holds no defined contents after reset; load every entry before sampling.
// reset empties the pipeline. when out_o.ready is low with a result waiting, the whole
// pipeline holds and in_i.ready drops in the same cycle; nothing is lost or repeated.

module gradient_noise_3d_unit
  import gn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gn3_in_if.sink     in_i,
  gn3_out_if.source  out_o
);

  localparam int GW  = FRAC_BITS + 3;
  localparam int FW  = FRAC_BITS + 1;
  localparam int LAT = 10;
  localparam logic signed [GW-1:0] LIM_POS = GW'(2) << FRAC_BITS;
  localparam logic signed [GW-1:0] LIM_NEG = -(GW'(2) << FRAC_BITS);

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                 input logic signed [FW-1:0] x,
                                                 input logic signed [FW-1:0] y,
                                                 input logic signed [FW-1:0] z);
    logic signed [GW-1:0] a, b;
    a = (h < 4'd8) ? GW'(x) : GW'(y);
    if (h < 4'd4) begin
      b = GW'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      b = GW'(x);
    end else begin
      b = GW'(z);
    end
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction

  logic en;
  logic [LAT:3] smp_q;

  // stage 1 and 2 control and payload
  logic v1_q, v2_q;
  mode_e mode1_q, mode2_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q;
  logic [PERM_W-1:0] val1_q, val2_q;
  logic [IDX_W-1:0]  cy1_q, cz1_q, cz2_q;
  logic [FRAC_BITS-1:0] fx1_q, fy1_q, fz1_q, fx2_q, fy2_q, fz2_q;

  logic [PERM_W-1:0] a_d [2];
  logic [PERM_W-1:0] b_d [4];
  logic [PERM_W-1:0] h_d [8];

  logic [IDX_W-1:0] cx_in, cy_in, cz_in;
  logic [FRAC_BITS-1:0] fx_in, fy_in, fz_in;

  logic [FRAC_BITS-1:0] u_d, v_d, w_d;
  logic [FRAC_BITS-1:0] u_q, v_dly_q [3], w_dly_q [5];
  logic signed [GW-1:0] g_q [8];
  logic signed [GW-1:0] pq_d [4];
  logic signed [GW-1:0] rs_d [2];
  logic signed [GW-1:0] res_d;
  logic signed [FW-1:0] xs [2], ys [2], zs [2];

  assign en         = !smp_q[LAT] || out_o.ready;
  assign in_i.ready = en;

  assign cx_in = in_i.coord_x[FRAC_BITS +: IDX_W];
  assign cy_in = in_i.coord_y[FRAC_BITS +: IDX_W];
  assign cz_in = in_i.coord_z[FRAC_BITS +: IDX_W];
  assign fx_in = in_i.coord_x[FRAC_BITS-1:0];
  assign fy_in = in_i.coord_y[FRAC_BITS-1:0];
  assign fz_in = in_i.coord_z[FRAC_BITS-1:0];

  // hash level 1: perm[x], perm[x+1]
  gn3_perm_ram u_ram_a (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (in_i.valid && in_i.mode == MODE_WRITE),
    .waddr_i  (in_i.table_index),
    .wdata_i  (in_i.table_value),
    .raddr0_i (cx_in),
    .raddr1_i (cx_in + IDX_W'(1)),
    .rdata0_o (a_d[0]),
    .rdata1_o (a_d[1])
  );

  // hash level 2: b[{j,i}] = perm[a[i] + y + j]
  for (genvar i = 0; i < 2; i++) begin : g_lvl2
    gn3_perm_ram u_ram_b (
      .clk_i    (clk_i),
      .en_i     (en),
      .we_i     (v1_q && mode1_q == MODE_WRITE),
      .waddr_i  (idx1_q),
      .wdata_i  (val1_q),
      .raddr0_i (a_d[i] + cy1_q),
      .raddr1_i (a_d[i] + cy1_q + IDX_W'(1)),
      .rdata0_o (b_d[i]),
      .rdata1_o (b_d[i+2])
    );
  end

  // hash level 3: h[{k,j,i}] = perm[b[{j,i}] + z + k]
  for (genvar m = 0; m < 4; m++) begin : g_lvl3
    gn3_perm_ram u_ram_c (
      .clk_i    (clk_i),
      .en_i     (en),
      .we_i     (v2_q && mode2_q == MODE_WRITE),
      .waddr_i  (idx2_q),
      .wdata_i  (val2_q),
      .raddr0_i (b_d[m] + cz2_q),
      .raddr1_i (b_d[m] + cz2_q + IDX_W'(1)),
      .rdata0_o (h_d[m]),
      .rdata1_o (h_d[m+4])
    );
  end

  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i (clk_i), .en_i (en), .frac_i (fx_in), .fade_o (u_d)
  );
  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i (clk_i), .en_i (en), .frac_i (fy_in), .fade_o (v_d)
  );
  gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
    .clk_i (clk_i), .en_i (en), .frac_i (fz_in), .fade_o (w_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      smp_q <= '0;
    end else if (en) begin
      v1_q  <= in_i.valid;
      v2_q  <= v1_q;
      smp_q <= {smp_q[LAT-1:3], v2_q && mode2_q == MODE_SAMPLE};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q <= in_i.mode;
      idx1_q  <= in_i.table_index;
      val1_q  <= in_i.table_value;
      cy1_q   <= cy_in;
      cz1_q   <= cz_in;
      fx1_q   <= fx_in;
      fy1_q   <= fy_in;
      fz1_q   <= fz_in;
      mode2_q <= mode1_q;
      idx2_q  <= idx1_q;
      val2_q  <= val1_q;
      cz2_q   <= cz1_q;
      fx2_q   <= fx1_q;
      fy2_q   <= fy1_q;
      fz2_q   <= fz1_q;
    end
  end

  // stage 3 fractions for the gradients
  logic [FRAC_BITS-1:0] fx3_q, fy3_q, fz3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      fz3_q <= fz2_q;
    end
  end

  // offset to the near corner and to the far corner
  assign xs[0] = $signed({1'b0, fx3_q});
  assign xs[1] = $signed({1'b1, fx3_q});
  assign ys[0] = $signed({1'b0, fy3_q});
  assign ys[1] = $signed({1'b1, fy3_q});
  assign zs[0] = $signed({1'b0, fz3_q});
  assign zs[1] = $signed({1'b1, fz3_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        g_q[c] <= grad(h_d[c][3:0], xs[c%2], ys[(c/2)%2], zs[c/4]);
      end
      u_q        <= u_d;
      v_dly_q[0] <= v_d;
      v_dly_q[1] <= v_dly_q[0];
      v_dly_q[2] <= v_dly_q[1];
      w_dly_q[0] <= w_d;
      for (int n = 1; n < 5; n++) begin
        w_dly_q[n] <= w_dly_q[n-1];
      end
    end
  end

  // x blend: pq[{k,j}] from corners {k,j,0} and {k,j,1}
  for (genvar m = 0; m < 4; m++) begin : g_lerp_x
    gn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk_i (clk_i), .en_i (en),
      .a_i (g_q[2*m]), .b_i (g_q[2*m+1]), .t_i (u_q), .res_o (pq_d[m])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_lerp_y
    gn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clk_i (clk_i), .en_i (en),
      .a_i (pq_d[2*k]), .b_i (pq_d[2*k+1]), .t_i (v_dly_q[2]), .res_o (rs_d[k])
    );
  end

  gn3_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
    .clk_i (clk_i), .en_i (en),
    .a_i (rs_d[0]), .b_i (rs_d[1]), .t_i (w_dly_q[4]), .res_o (res_d)
  );

  assign out_o.valid       = smp_q[LAT];
  assign out_o.noise_value = res_d;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(smp_q) && $stable(v1_q) && $stable(v2_q))
    else $error("pipeline valid bits moved during a stall");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (res_d <= LIM_POS) && (res_d >= LIM_NEG))
    else $error("noise result outside +-2.0");

  a_grad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_q[4] |-> (g_q[0] <= LIM_POS) && (g_q[0] >= LIM_NEG)
              && (g_q[7] <= LIM_POS) && (g_q[7] >= LIM_NEG))
    else $error("corner gradient outside +-2.0");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the result beat is stalled");

endmodule
